@@ rtl/bprs_pkg.sv @@
// Shared types and constants for the binary prefix route selector.
`default_nettype none

package bprs_pkg;

  // Width of the input length field.
  localparam int BPRS_LEN_IN_W = 6;
  // Width of a route number.
  localparam int BPRS_ROUTE_W  = 16;

  typedef enum logic [1:0] {
    BPRS_ST_FOUND  = 2'd0,
    BPRS_ST_NONE   = 2'd1,
    BPRS_ST_STORED = 2'd2,
    BPRS_ST_FULL   = 2'd3
  } bprs_status_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load;      // capture an accepted item, clear scan results
    logic rd_en;     // read one table entry
    logic eval_ins;  // read data holds an entry: insert compare
    logic eval_p1;   // read data holds an entry: shared-length pass
    logic eval_p2;   // read data holds an entry: shortest-prefix pass
    logic fin_ins;   // finish insert: write entry if matched or not full, load result
    logic fin_lk;    // finish lookup: load result
    logic full;      // every entry is in use
  } bprs_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic ins_match;  // an equal prefix is already stored
  } bprs_stat_t;

endpackage

`default_nettype wire

@@ rtl/binary_prefix_route_select_top.sv @@
// Top level of the binary prefix route selector: sequencer plus datapath.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   mode, address_bits, address_length, route_number
//   out_     output     out_valid/out_stall status, route_result
//
// One item at a time. The result register loads after the single-port table scan (one
// entry read per cycle, once for inserts, twice for lookups), and the next transfer in
// can follow once the sequencer is back in idle.
// Synchronous active-low reset empties the table through the fill count.
// A result waiting under out_stall does not block the next transfer in; a finished item
// waits in its last state until the output register is free.
`default_nettype none

module binary_prefix_route_select_top #(
  parameter int TABLE_ENTRIES = 64,
  parameter int KEY_BITS      = 32
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire                                 in_mode,
  input  wire  [KEY_BITS-1:0]                 in_address_bits,
  input  wire  [bprs_pkg::BPRS_LEN_IN_W-1:0]  in_address_length,
  input  wire  [bprs_pkg::BPRS_ROUTE_W-1:0]   in_route_number,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic [1:0]                          out_status,
  output logic [bprs_pkg::BPRS_ROUTE_W-1:0]   out_route_result
);
  import bprs_pkg::*;

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  bprs_cmd_t     cmd;
  bprs_stat_t    stat;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] eval_idx;
  logic [AW-1:0] new_addr;

  bprs_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .AW            (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_mode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .eval_idx  (eval_idx),
    .new_addr  (new_addr),
    .stat      (stat)
  );

  bprs_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .KEY_BITS      (KEY_BITS),
    .AW            (AW)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .rd_addr           (rd_addr),
    .eval_idx          (eval_idx),
    .new_addr          (new_addr),
    .in_address_bits   (in_address_bits),
    .in_address_length (in_address_length),
    .in_route_number   (in_route_number),
    .out_status        (out_status),
    .out_route_result  (out_route_result),
    .stat              (stat)
  );

endmodule

`default_nettype wire

@@ rtl/bprs_datapath.sv @@
// Datapath: entry table memory, key registers, per-entry compare and result registers.
`default_nettype none

module bprs_datapath #(
  parameter int TABLE_ENTRIES = 64,
  parameter int KEY_BITS      = 32,
  parameter int AW            = 6
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  bprs_pkg::bprs_cmd_t                 cmd,
  input  wire  [AW-1:0]                       rd_addr,
  input  wire  [AW-1:0]                       eval_idx,
  input  wire  [AW-1:0]                       new_addr,
  input  wire  [KEY_BITS-1:0]                 in_address_bits,
  input  wire  [bprs_pkg::BPRS_LEN_IN_W-1:0]  in_address_length,
  input  wire  [bprs_pkg::BPRS_ROUTE_W-1:0]   in_route_number,
  output logic [1:0]                          out_status,
  output logic [bprs_pkg::BPRS_ROUTE_W-1:0]   out_route_result,
  output bprs_pkg::bprs_stat_t                stat
);
  import bprs_pkg::*;

  localparam int LW = $clog2(KEY_BITS + 1);
  localparam int XW = (LW > BPRS_LEN_IN_W) ? LW : BPRS_LEN_IN_W;
  localparam int EW = KEY_BITS + LW + BPRS_ROUTE_W;

  // Thermometer mask of the top n bits of a key.
  function automatic logic [KEY_BITS-1:0] lead_mask(input logic [LW-1:0] n);
    logic [KEY_BITS-1:0] m;
    m = '0;
    for (int i = 0; i < KEY_BITS; i++) begin
      m[i] = (({1'b0, n} + (LW+1)'(i)) >= (LW+1)'(KEY_BITS));
    end
    return m;
  endfunction

  logic [EW-1:0]           mem [TABLE_ENTRIES];
  logic [EW-1:0]           rdata_r;

  logic [KEY_BITS-1:0]     key_r;
  logic [LW-1:0]           len_r;
  logic [BPRS_ROUTE_W-1:0] route_r;

  logic                    match_r, match_nxt;
  logic [AW-1:0]           match_idx_r, match_idx_nxt;
  logic [LW-1:0]           deepest_r, deepest_nxt;
  logic                    found_r, found_nxt;
  logic [LW-1:0]           best_len_r, best_len_nxt;
  logic [KEY_BITS-1:0]     best_prefix_r, best_prefix_nxt;
  logic [BPRS_ROUTE_W-1:0] best_route_r, best_route_nxt;
  bprs_status_t            status_r;
  logic [BPRS_ROUTE_W-1:0] result_r;

  logic [KEY_BITS-1:0]     rd_prefix;
  logic [LW-1:0]           rd_len;
  logic [BPRS_ROUTE_W-1:0] rd_route;

  logic [XW-1:0]           len_ext;
  logic [LW-1:0]           len_sat;
  logic [LW-1:0]           lim;
  logic [KEY_BITS-1:0]     capped;
  logic [KEY_BITS-1:0]     first_one;
  logic [LW-1:0]           shared;
  logic                    qual, better;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;

  assign rd_prefix = rdata_r[EW-1 -: KEY_BITS];
  assign rd_len    = rdata_r[BPRS_ROUTE_W +: LW];
  assign rd_route  = rdata_r[BPRS_ROUTE_W-1:0];

  // Saturate the requested length at the key width.
  always_comb begin
    len_ext = XW'(in_address_length);
    if (len_ext > XW'(KEY_BITS)) begin
      len_sat = LW'(KEY_BITS);
    end else begin
      len_sat = len_ext[LW-1:0];
    end
  end

  // Shared leading bits of key and entry, capped at the shorter length.
  always_comb begin
    lim = (rd_len < len_r) ? rd_len : len_r;
    capped = rd_prefix ^ key_r;
    for (int i = 0; i < KEY_BITS; i++) begin
      if ((LW+1)'(lim) + (LW+1)'(i) == (LW+1)'(KEY_BITS - 1)) begin
        capped[i] = 1'b1;
      end
    end
    shared = '0;
    for (int i = 0; i < KEY_BITS; i++) begin
      first_one[i] = capped[i] && ((capped >> (i + 1)) == '0);
      if (first_one[i]) begin
        shared = shared | LW'(KEY_BITS - 1 - i);
      end
    end
    if (capped == '0) begin
      shared = LW'(KEY_BITS);
    end
  end

  always_comb begin
    qual = (rd_len >= deepest_r) && (((rd_prefix ^ key_r) & lead_mask(deepest_r)) == '0);
    better = !found_r || (rd_len < best_len_r) ||
             ((rd_len == best_len_r) && (rd_prefix < best_prefix_r));
  end

  always_comb begin
    match_nxt       = match_r;
    match_idx_nxt   = match_idx_r;
    deepest_nxt     = deepest_r;
    found_nxt       = found_r;
    best_len_nxt    = best_len_r;
    best_prefix_nxt = best_prefix_r;
    best_route_nxt  = best_route_r;
    if (cmd.load) begin
      match_nxt   = 1'b0;
      deepest_nxt = '0;
      found_nxt   = 1'b0;
    end
    if (cmd.eval_ins && !match_r && (rd_len == len_r) && (rd_prefix == key_r)) begin
      match_nxt     = 1'b1;
      match_idx_nxt = eval_idx;
    end
    if (cmd.eval_p1 && (shared > deepest_r)) begin
      deepest_nxt = shared;
    end
    if (cmd.eval_p2 && qual && better) begin
      found_nxt       = 1'b1;
      best_len_nxt    = rd_len;
      best_prefix_nxt = rd_prefix;
      best_route_nxt  = rd_route;
    end
  end

  assign wr_en   = cmd.fin_ins && (match_r || !cmd.full);
  assign wr_addr = match_r ? match_idx_r : new_addr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {key_r, len_r, route_r};
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r   <= 1'b0;
      deepest_r <= '0;
      found_r   <= 1'b0;
    end else begin
      match_r   <= match_nxt;
      deepest_r <= deepest_nxt;
      found_r   <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    match_idx_r   <= match_idx_nxt;
    best_len_r    <= best_len_nxt;
    best_prefix_r <= best_prefix_nxt;
    best_route_r  <= best_route_nxt;
    if (cmd.load) begin
      key_r   <= in_address_bits & lead_mask(len_sat);
      len_r   <= len_sat;
      route_r <= in_route_number;
    end
    if (cmd.fin_ins) begin
      status_r <= (match_r || !cmd.full) ? BPRS_ST_STORED : BPRS_ST_FULL;
      result_r <= '0;
    end else if (cmd.fin_lk) begin
      status_r <= found_r ? BPRS_ST_FOUND : BPRS_ST_NONE;
      result_r <= found_r ? best_route_r : '0;
    end
  end

  assign out_status       = status_r;
  assign out_route_result = result_r;
  assign stat.ins_match   = match_r;

endmodule

`default_nettype wire

@@ rtl/bprs_ctrl.sv @@
// Sequencer: handshakes, table scan counter, fill count and pass control.
`default_nettype none

module bprs_ctrl #(
  parameter int TABLE_ENTRIES = 64,
  parameter int AW            = 6
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  input  wire                   in_mode,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire                   out_stall,
  output bprs_pkg::bprs_cmd_t   cmd,
  output logic [AW-1:0]         rd_addr,
  output logic [AW-1:0]         eval_idx,
  output logic [AW-1:0]         new_addr,
  input  bprs_pkg::bprs_stat_t  stat
);
  import bprs_pkg::*;

  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_INS  = 5'b00010,
    S_LK1  = 5'b00100,
    S_LK2  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          eval_r, eval_nxt;
  logic [AW-1:0] eval_idx_r;
  logic          mode_r, mode_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          scanning, rd, pass_done, full, fin_go;

  assign full      = (count_r == CW'(TABLE_ENTRIES));
  assign scanning  = (state_r == S_INS) || (state_r == S_LK1) || (state_r == S_LK2);
  assign rd        = scanning && (idx_r < count_r);
  assign pass_done = scanning && !rd && !eval_r;
  assign fin_go    = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  always_comb begin
    cmd          = '0;
    cmd.load     = (state_r == S_IDLE) && in_valid;
    cmd.rd_en    = rd;
    cmd.eval_ins = eval_r && (state_r == S_INS);
    cmd.eval_p1  = eval_r && (state_r == S_LK1);
    cmd.eval_p2  = eval_r && (state_r == S_LK2);
    cmd.fin_ins  = fin_go && mode_r;
    cmd.fin_lk   = fin_go && !mode_r;
    cmd.full     = full;
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    mode_nxt      = mode_r;
    eval_nxt      = rd;
    out_valid_nxt = out_valid_r && out_stall;
    if (rd) begin
      idx_nxt = idx_r + 1'b1;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt  = in_mode;
          idx_nxt   = '0;
          state_nxt = in_mode ? S_INS : S_LK1;
        end
      end
      S_INS: begin
        if (pass_done) state_nxt = S_FIN;
      end
      S_LK1: begin
        if (pass_done) begin
          idx_nxt   = '0;
          state_nxt = S_LK2;
        end
      end
      S_LK2: begin
        if (pass_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (fin_go) begin
          out_valid_nxt = 1'b1;
          if (mode_r && !stat.ins_match && !full) begin
            count_nxt = count_r + 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      count_r     <= '0;
      eval_r      <= 1'b0;
      mode_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      count_r     <= count_nxt;
      eval_r      <= eval_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Index of the entry being read, registered alongside its read data.
  always_ff @(posedge clk) begin
    eval_idx_r <= idx_r[AW-1:0];
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign rd_addr   = idx_r[AW-1:0];
  assign eval_idx  = eval_idx_r;
  assign new_addr  = count_r[AW-1:0];

endmodule

`default_nettype wire
